// File: hw/rtl/fat_pkg.sv
// shared types and constants of the flow accounting table
package fat_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int LIMIT_W = 7;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 32;

    // opcodes of an input item
    localparam logic OP_COLLECT = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_LIMIT     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_OVERFLOW = 8'd1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [31:0] bytes_in;
        logic [31:0] bytes_out;
        logic [15:0] pkts_in;
        logic [15:0] packets_out;
    } flow_in_t;

    typedef struct packed {
        logic        overlimit;
        logic        flow_dropped;
        logic        entry_valid;
        logic [31:0] flow_ip_low;
        logic [31:0] flow_ip_high;
        logic [15:0] flow_port_low;
        logic [15:0] flow_port_high;
        logic [7:0]  flow_protocol;
        logic [63:0] total_bytes_in;
        logic [63:0] total_bytes_out;
        logic [63:0] total_pkts_in;
        logic [63:0] total_packets_out;
    } flow_out_t;

    // kind of pass a token makes down the cell row
    typedef enum logic [1:0] {
        TK_COLLECT,
        TK_INSERT,
        TK_DRAIN
    } tok_kind_t;

    // token handed from cell to cell
    typedef struct packed {
        logic        active;
        tok_kind_t   kind;
        logic        done;
        logic        free_seen;
        logic        top_bit;
        logic [63:0] key_ip;
        logic [39:0] key_pp;
        logic [31:0] add_bi;
        logic [31:0] add_bo;
        logic [15:0] add_pi;
        logic [15:0] add_po;
        logic [63:0] out_ip;
        logic [39:0] out_pp;
        logic [63:0] out_bi;
        logic [63:0] out_bo;
        logic [63:0] out_pi;
        logic [63:0] out_po;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/fat_cell.sv
// one table slot: key, counters and the token stage to the next slot
module fat_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  fat_pkg::tok_t tok_in,
    output fat_pkg::tok_t tok_out
);

    logic          used_reg, used_next;
    logic [63:0]   ip_reg, ip_next;
    logic [39:0]   pp_reg, pp_next;
    logic [63:0]   bi_reg, bi_next;
    logic [63:0]   bo_reg, bo_next;
    logic [63:0]   pi_reg, pi_next;
    logic [63:0]   po_reg, po_next;
    fat_pkg::tok_t tok_reg, tok_next;
    logic [63:0]   sum_bi, sum_bo;
    logic          match;

    assign sum_bi = bi_reg + {32'd0, tok_in.add_bi};
    assign sum_bo = bo_reg + {32'd0, tok_in.add_bo};
    assign match  = used_reg && (ip_reg == tok_in.key_ip) && (pp_reg == tok_in.key_pp);

    // slot update and token forwarding
    always_comb begin
        used_next = used_reg;
        ip_next   = ip_reg;
        pp_next   = pp_reg;
        bi_next   = bi_reg;
        bo_next   = bo_reg;
        pi_next   = pi_reg;
        po_next   = po_reg;
        tok_next  = tok_in;
        if (tok_in.active) begin
            unique case (tok_in.kind)
                fat_pkg::TK_COLLECT: begin
                    if (!tok_in.done && match) begin
                        bi_next          = sum_bi;
                        bo_next          = sum_bo;
                        pi_next          = pi_reg + {48'd0, tok_in.add_pi};
                        po_next          = po_reg + {48'd0, tok_in.add_po};
                        tok_next.done    = 1'b1;
                        tok_next.top_bit = sum_bi[63] | sum_bo[63];
                    end
                    if (!used_reg) begin
                        tok_next.free_seen = 1'b1;
                    end
                end
                fat_pkg::TK_INSERT: begin
                    if (!tok_in.done && !used_reg) begin
                        used_next        = 1'b1;
                        ip_next          = tok_in.key_ip;
                        pp_next          = tok_in.key_pp;
                        bi_next          = {32'd0, tok_in.add_bi};
                        bo_next          = {32'd0, tok_in.add_bo};
                        pi_next          = {48'd0, tok_in.add_pi};
                        po_next          = {48'd0, tok_in.add_po};
                        tok_next.done    = 1'b1;
                        tok_next.top_bit = 1'b0;
                    end
                end
                fat_pkg::TK_DRAIN: begin
                    if (!tok_in.done && used_reg) begin
                        used_next       = 1'b0;
                        tok_next.done   = 1'b1;
                        tok_next.out_ip = ip_reg;
                        tok_next.out_pp = pp_reg;
                        tok_next.out_bi = bi_reg;
                        tok_next.out_bo = bo_reg;
                        tok_next.out_pi = pi_reg;
                        tok_next.out_po = po_reg;
                    end
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        ip_reg <= ip_next;
        pp_reg <= pp_next;
        bi_reg <= bi_next;
        bo_reg <= bo_next;
        pi_reg <= pi_next;
        po_reg <= po_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: hw/rtl/flow_accounting_table.sv
// top level of the flow accounting table: sequencer, registers and the slot row
// Five-tuple flow table built as a row of TABLE_DEPTH slot cells; a request token walks
// the row one cell per cycle. A collect hitting a stored flow, a dropped flow or a drain
// makes a single pass down the row; a collect of a new flow makes a second insert pass.
// The length of the cell row sets how long a pass takes. One item is in work at a time;
// a finished result sits in the output register while the next item is taken.
// Configuration writes are taken in any cycle and must only be made while the
// block is idle.
module flow_accounting_table #(
    parameter int TABLE_DEPTH = fat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fat_pkg::flow_in_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fat_pkg::flow_out_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fat_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fat_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > fat_pkg::LIMIT_W) ? CNT_W : fat_pkg::LIMIT_W) + 1;

    fat_pkg::state_t            state_reg, state_next;
    fat_pkg::tok_t              req_reg, req_next;
    logic                       launch_reg, launch_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [fat_pkg::LIMIT_W-1:0] limit_reg;
    logic                       chk_reg;
    fat_pkg::flow_out_t         res_reg, res_next;
    logic                       m_valid_reg, m_valid_next;
    fat_pkg::flow_out_t         m_data_reg, m_data_next;
    fat_pkg::tok_t              chain [0:TABLE_DEPTH];
    fat_pkg::tok_t              tail;
    logic [CMP_W-1:0]           cnt_ext, cnt_inc, lim_ext;
    logic                       swap;

    // slot row
    always_comb begin
        chain[0]        = req_reg;
        chain[0].active = launch_reg;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            fat_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (chain[g]),
                .tok_out (chain[g+1])
            );
        end
    endgenerate

    assign tail    = chain[TABLE_DEPTH];
    assign cnt_ext = CMP_W'(count_reg);
    assign cnt_inc = cnt_ext + CMP_W'(1);
    assign lim_ext = CMP_W'(limit_reg);
    assign swap    = (s_data.src_ip > s_data.dst_ip) ||
                     ((s_data.src_ip == s_data.dst_ip) && (s_data.src_port > s_data.dst_port));

    assign s_ready   = (state_reg == fat_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        launch_next  = 1'b0;
        count_next   = count_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            fat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next = '0;
                    req_next.kind = (s_data.opcode == fat_pkg::OP_DRAIN) ?
                                    fat_pkg::TK_DRAIN : fat_pkg::TK_COLLECT;
                    if (swap) begin
                        req_next.key_ip = {s_data.dst_ip, s_data.src_ip};
                        req_next.key_pp = {s_data.dst_port, s_data.src_port, s_data.protocol};
                        req_next.add_bi = s_data.bytes_out;
                        req_next.add_bo = s_data.bytes_in;
                        req_next.add_pi = s_data.packets_out;
                        req_next.add_po = s_data.pkts_in;
                    end else begin
                        req_next.key_ip = {s_data.src_ip, s_data.dst_ip};
                        req_next.key_pp = {s_data.src_port, s_data.dst_port, s_data.protocol};
                        req_next.add_bi = s_data.bytes_in;
                        req_next.add_bo = s_data.bytes_out;
                        req_next.add_pi = s_data.pkts_in;
                        req_next.add_po = s_data.packets_out;
                    end
                    launch_next = 1'b1;
                    state_next  = fat_pkg::ST_SEARCH;
                end
            end
            fat_pkg::ST_SEARCH: begin
                if (tail.active) begin
                    res_next = '0;
                    state_next = fat_pkg::ST_DONE;
                    if (tail.kind == fat_pkg::TK_DRAIN) begin
                        res_next.entry_valid       = tail.done;
                        res_next.flow_ip_low       = tail.out_ip[63:32];
                        res_next.flow_ip_high      = tail.out_ip[31:0];
                        res_next.flow_port_low     = tail.out_pp[39:24];
                        res_next.flow_port_high    = tail.out_pp[23:8];
                        res_next.flow_protocol     = tail.out_pp[7:0];
                        res_next.total_bytes_in    = tail.out_bi;
                        res_next.total_bytes_out   = tail.out_bo;
                        res_next.total_pkts_in     = tail.out_pi;
                        res_next.total_packets_out = tail.out_po;
                        if (tail.done && (count_reg != '0)) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end else if (tail.done) begin
                        res_next.overlimit = (chk_reg && tail.top_bit) || (cnt_ext > lim_ext);
                    end else if (tail.free_seen) begin
                        req_next.kind = fat_pkg::TK_INSERT;
                        launch_next   = 1'b1;
                        state_next    = fat_pkg::ST_INSERT;
                    end else begin
                        res_next.overlimit    = (cnt_inc > lim_ext);
                        res_next.flow_dropped = 1'b1;
                    end
                end
            end
            fat_pkg::ST_INSERT: begin
                if (tail.active) begin
                    res_next           = '0;
                    count_next         = count_reg + CNT_W'(1);
                    res_next.overlimit = (chk_reg && tail.top_bit) || (cnt_inc > lim_ext);
                    state_next         = fat_pkg::ST_DONE;
                end
            end
            fat_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = fat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fat_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fat_pkg::ST_IDLE;
            launch_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= 7'd64;
            chk_reg     <= 1'b1;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fat_pkg::CFG_FLOW_LIMIT) begin
                    limit_reg <= cfg_data[fat_pkg::LIMIT_W-1:0];
                end else if (cfg_index == fat_pkg::CFG_CHECK_OVERFLOW) begin
                    chk_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule
